FILE: hw/rtl/ppdif_pkg.sv
`default_nettype none
package ppdif_pkg;

	localparam int COLUMNS       = 384;
	localparam int ROWS          = 216;
	localparam int SEARCH_RADIUS = 7;

	localparam int DEPTH   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int QCOL_W  = 9;
	localparam int QROW_W  = 8;
	localparam int CODE_W  = 8;
	localparam int COORD_W = 32;
	localparam int FACT_W  = 16;
	localparam int SCALE_W = 8;

	localparam int MAX_DIM = (COLUMNS > ROWS) ? COLUMNS : ROWS;
	localparam int QUO_W   = $clog2(MAX_DIM + 1);
	localparam int OFF_W   = $clog2(SEARCH_RADIUS + 1) + 1;
	localparam int DIST_W  = $clog2(2 * SEARCH_RADIUS * SEARCH_RADIUS + 1);

	localparam logic [FACT_W-1:0]  HN_RESET    = 16'd5636;
	localparam logic [FACT_W-1:0]  VN_RESET    = 16'd10138;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd50;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_POINT = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_POINT,
		OP_QUERY
	} op_t;

	typedef enum logic [1:0] {
		REG_HN    = 2'd0,
		REG_VN    = 2'd1,
		REG_SCALE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		op_t                       op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [QCOL_W-1:0]         col;
		logic [QROW_W-1:0]         row;
	} item_t;

	typedef struct packed {
		logic init_busy;
		logic idle;
	} back_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ppdif_ram.sv
`default_nettype none
module ppdif_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ppdif_front.sv
`default_nettype none
module ppdif_front import ppdif_pkg::*; (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       item_valid,
	output logic                      item_ready,
	input  wire [1:0]                 command,
	input  wire signed [COORD_W-1:0]  point_x,
	input  wire signed [COORD_W-1:0]  point_y,
	input  wire signed [COORD_W-1:0]  point_z,
	input  wire [QCOL_W-1:0]          query_column,
	input  wire [QROW_W-1:0]          query_row,
	input  back_stat_t                stat,
	output logic                      q_valid,
	output item_t                     q_item,
	input  wire                       q_pop
);

	item_t       fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        transfer, keep, push;
	logic signed [COORD_W:0] ax, ay;
	item_t       entry;

	assign item_ready = (count_q != 2'd2) && !stat.init_busy;
	assign transfer   = item_valid && item_ready;

	// points behind the sensor or outside the lateral cone never reach the store
	assign ax = {point_x[COORD_W-1], point_x};
	assign ay = point_y[COORD_W-1] ? -{point_y[COORD_W-1], point_y}
	                               : {point_y[COORD_W-1], point_y};

	always_comb begin
		entry     = '0;
		entry.x   = point_x;
		entry.y   = point_y;
		entry.z   = point_z;
		entry.col = query_column;
		entry.row = query_row;
		keep      = 1'b0;
		unique case (command)
			CMD_CLEAR: begin
				entry.op = OP_CLEAR;
				keep     = 1'b1;
			end
			CMD_POINT: begin
				entry.op = OP_POINT;
				keep     = (ax > 0) && (ax >= ay);
			end
			CMD_QUERY: begin
				entry.op = OP_QUERY;
				keep     = 1'b1;
			end
			default: begin
				entry.op = OP_CLEAR;
				keep     = 1'b0;
			end
		endcase
	end

	assign push    = transfer && keep;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ppdif_back.sv
`default_nettype none
module ppdif_back import ppdif_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	input  item_t                q_item,
	output logic                 q_pop,
	output back_stat_t           stat,
	input  wire [FACT_W-1:0]     horizontal_factor,
	input  wire [FACT_W-1:0]     vertical_factor,
	input  wire [SCALE_W-1:0]    depth_scale,
	output logic                 ram_we,
	output logic [ADDR_W-1:0]    ram_waddr,
	output logic [CODE_W-1:0]    ram_wdata,
	output logic [ADDR_W-1:0]    ram_raddr,
	input  wire [CODE_W-1:0]     ram_rdata,
	output logic                 result_valid,
	input  wire                  result_ready,
	output logic [CODE_W-1:0]    depth_code
);

	localparam int STEP_W = 4;
	localparam int NUM_W  = 45;
	localparam int REM_W  = 56;
	localparam int POS_W  = 12;
	localparam int PROD_W = 66;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_PMUL, ST_DIVC, ST_DIVR, ST_SQRT, ST_PWRITE,
		ST_QCENTER, ST_QWAIT, ST_QSCAN, ST_QLAST, ST_QDONE
	} st_t;

	st_t state_q, state_d;
	item_t item_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [32:0]      mul_a, mul_b;
	logic [63:0]             s_q;
	logic [15:0]             sc2_q;
	logic [47:0]             alo_q;
	logic [32:0]             m_q;
	logic                    big_q;
	logic [NUM_W-1:0]        num_h_q, num_v_q;
	logic [REM_W-1:0]        rem_q, trial;
	logic [QUO_W-1:0]        quo_q, quo_d;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [7:0]              root_q, root_t;
	logic [15:0]             root_sq;
	logic [ADDR_W-1:0]       clr_q;
	logic                    init_q;
	logic signed [OFF_W-1:0] dc_q, dr_q;
	logic [DIST_W-1:0]       best_q, d_s1, win_dist;
	logic                    v_s1;
	logic [CODE_W-1:0]       res_q, out_q, code;
	logic                    out_valid_q, out_load;
	logic signed [PROD_W-1:0] den_s, num_s;
	logic                    out_of_view, rem_ge, clr_last, scan_last, pos_in, take;
	logic signed [POS_W-1:0] pos_c, pos_r;
	logic signed [2*OFF_W-1:0] dc2, dr2;
	logic [ADDR_W-1:0]       pos_addr, pt_addr;

	localparam logic signed [POS_W-1:0] COL_LIM = POS_W'(COLUMNS);
	localparam logic signed [POS_W-1:0] ROW_LIM = POS_W'(ROWS);
	localparam logic signed [OFF_W-1:0] RAD     = OFF_W'(SEARCH_RADIUS);

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			4'd0: begin mul_a = {17'b0, horizontal_factor}; mul_b = {item_q.y[31], item_q.y}; end
			4'd1: begin mul_a = {17'b0, vertical_factor}; mul_b = {item_q.z[31], item_q.z}; end
			4'd2: begin mul_a = {item_q.x[31], item_q.x}; mul_b = {item_q.x[31], item_q.x}; end
			4'd3: begin mul_a = {item_q.y[31], item_q.y}; mul_b = {item_q.y[31], item_q.y}; end
			4'd4: begin mul_a = {item_q.z[31], item_q.z}; mul_b = {item_q.z[31], item_q.z}; end
			4'd5: begin mul_a = {25'b0, depth_scale}; mul_b = {25'b0, depth_scale}; end
			4'd6: begin mul_a = {17'b0, prod_q[15:0]}; mul_b = {1'b0, s_q[31:0]}; end
			4'd7: begin mul_a = {17'b0, sc2_q}; mul_b = {16'b0, s_q[48:32]}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign den_s       = $signed({22'b0, item_q.x, 12'b0});
	assign out_of_view = (prod_q > den_s) || (prod_q < -den_s);
	assign num_s       = den_s - prod_q;

	// restoring division, one quotient bit a cycle
	assign trial  = REM_W'({item_q.x[30:0], 13'b0}) << step_q;
	assign rem_ge = rem_q >= trial;
	assign quo_d  = quo_q | (QUO_W'(rem_ge) << step_q);

	assign root_t  = root_q | (8'd1 << step_q[2:0]);
	assign root_sq = 16'(root_t) * 16'(root_t);

	always_comb begin
		if (big_q) code = (depth_scale == '0) ? '0 : 8'hff;
		else if (m_q[32:16] != '0) code = 8'hff;
		else code = root_q;
	end

	assign pos_c  = $signed(POS_W'(item_q.col)) + POS_W'(dc_q);
	assign pos_r  = $signed(POS_W'(item_q.row)) + POS_W'(dr_q);
	assign pos_in = (pos_c >= 0) && (pos_c < COL_LIM) && (pos_r >= 0) && (pos_r < ROW_LIM);
	assign pos_addr = ADDR_W'(pos_c[COL_W-1:0]) + ADDR_W'(pos_r[ROW_W-1:0]) * ADDR_W'(COLUMNS);
	assign pt_addr  = ADDR_W'(col_q) + ADDR_W'(row_q) * ADDR_W'(COLUMNS);
	assign dc2  = dc_q * dc_q;
	assign dr2  = dr_q * dr_q;
	assign win_dist = DIST_W'(dc2 + dr2);
	assign scan_last = (dc_q == RAD) && (dr_q == RAD);
	assign clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
	assign take      = v_s1 && (ram_rdata != '0) && (d_s1 < best_q);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = pos_addr;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.op)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_POINT: state_d = ST_PMUL;
						OP_QUERY: state_d = ST_QCENTER;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_PMUL: begin
				if ((step_q == 4'd1 || step_q == 4'd2) && out_of_view) state_d = ST_IDLE;
				else if (step_q == 4'd8) state_d = ST_DIVC;
			end
			ST_DIVC: if (step_q == '0) state_d = ST_DIVR;
			ST_DIVR: if (step_q == '0) state_d = ST_SQRT;
			ST_SQRT: if (step_q == '0) state_d = ST_PWRITE;
			ST_PWRITE: begin
				ram_we    = 1'b1;
				ram_waddr = pt_addr;
				ram_wdata = code;
				state_d   = ST_IDLE;
			end
			ST_QCENTER: state_d = pos_in ? ST_QWAIT : ST_QDONE;
			ST_QWAIT:   state_d = (ram_rdata != '0) ? ST_QDONE : ST_QSCAN;
			ST_QSCAN:   if (scan_last) state_d = ST_QLAST;
			ST_QLAST:   state_d = ST_QDONE;
			ST_QDONE: begin
				if (!out_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
				if (clr_last) init_q <= 1'b0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					item_q <= q_item;
					step_q <= '0;
					dc_q   <= '0;
					dr_q   <= '0;
				end
			end
			ST_PMUL: begin
				prod_q <= mul_a * mul_b;
				step_q <= (step_q == 4'd8) ? STEP_W'(QUO_W - 1) : step_q + 1'b1;
				case (step_q)
					4'd1: num_h_q <= num_s[NUM_W-1:0];
					4'd2: num_v_q <= num_s[NUM_W-1:0];
					4'd3: s_q <= prod_q[63:0];
					4'd4, 4'd5: s_q <= s_q + prod_q[63:0];
					4'd6: sc2_q <= prod_q[15:0];
					4'd7: alo_q <= prod_q[47:0];
					4'd8: begin
						// only the upper half of scale^2 * s feeds the root
						m_q    <= 33'(alo_q[47:32]) + prod_q[32:0];
						big_q  <= s_q > (64'd1 << 48);
						rem_q  <= REM_W'(num_h_q) * REM_W'(COLUMNS);
						quo_q  <= '0;
					end
					default: ;
				endcase
			end
			ST_DIVC, ST_DIVR: begin
				if (step_q != '0) begin
					if (rem_ge) rem_q <= rem_q - trial;
					quo_q  <= quo_d;
					step_q <= step_q - 1'b1;
				end else if (state_q == ST_DIVC) begin
					col_q  <= (quo_d >= QUO_W'(COLUMNS)) ? COL_W'(COLUMNS - 1)
					                                     : quo_d[COL_W-1:0];
					rem_q  <= REM_W'(num_v_q) * REM_W'(ROWS);
					quo_q  <= '0;
					step_q <= STEP_W'(QUO_W - 1);
				end else begin
					row_q  <= (quo_d >= QUO_W'(ROWS)) ? ROW_W'(ROWS - 1)
					                                  : quo_d[ROW_W-1:0];
					root_q <= '0;
					step_q <= STEP_W'(7);
				end
			end
			ST_SQRT: begin
				if (root_sq <= m_q[15:0]) root_q <= root_t;
				step_q <= step_q - 1'b1;
			end
			ST_QCENTER: res_q <= '0;
			ST_QWAIT: begin
				res_q  <= ram_rdata;
				dc_q   <= -RAD;
				dr_q   <= -RAD;
				best_q <= DIST_W'(SEARCH_RADIUS * SEARCH_RADIUS);
				v_s1   <= 1'b0;
			end
			ST_QSCAN: begin
				v_s1 <= pos_in;
				d_s1 <= win_dist;
				if (dr_q == RAD) begin
					dr_q <= -RAD;
					dc_q <= dc_q + 1'b1;
				end else begin
					dr_q <= dr_q + 1'b1;
				end
				if (take) begin
					best_q <= d_s1;
					res_q  <= ram_rdata;
				end
			end
			ST_QLAST: begin
				if (take) begin
					best_q <= d_s1;
					res_q  <= ram_rdata;
				end
			end
			ST_QDONE: if (out_load) out_q <= res_q;
			default: ;
		endcase
	end

	assign result_valid   = out_valid_q;
	assign depth_code     = out_q;
	assign stat.init_busy = init_q;
	assign stat.idle      = (state_q == ST_IDLE);

	a_we_only_clear_or_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_PWRITE))
		else $error("store written outside clear or point write");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE && !init_q))
		else $error("queue popped while busy");
	a_load_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == ST_QDONE)
		else $error("result loaded outside query completion");
	a_scan_continues: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QSCAN |=> (state_q == ST_QSCAN || state_q == ST_QLAST))
		else $error("window scan left early");

endmodule
`default_nettype wire

FILE: hw/rtl/point_projection_depth_image_fill.sv
// channel  | handshake                  | payload
// config   | psel penable pwrite pready | paddr pwdata prdata
// item     | item_valid item_ready      | command point_x point_y point_z query_column query_row
// result   | result_valid result_ready  | depth_code
//
// a point passes through the shared 33x33 multiplier, then the column and row
// divides, the root and one store write
// a query reads the store one cell a cycle: the centre cell first, and the window only on a miss
// a clear sweeps all 82944 store entries at one entry a cycle; the same sweep
// runs after reset and items are held off until it ends
// a two-entry queue lets new items transfer while a result waits to be taken
`default_nettype none
module point_projection_depth_image_fill import ppdif_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      psel,
	input  wire                      penable,
	input  wire                      pwrite,
	input  wire [3:0]                paddr,
	input  wire [31:0]               pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire                      item_valid,
	output logic                     item_ready,
	input  wire [1:0]                command,
	input  wire signed [COORD_W-1:0] point_x,
	input  wire signed [COORD_W-1:0] point_y,
	input  wire signed [COORD_W-1:0] point_z,
	input  wire [QCOL_W-1:0]         query_column,
	input  wire [QROW_W-1:0]         query_row,
	output logic                     result_valid,
	input  wire                      result_ready,
	output logic [CODE_W-1:0]        depth_code
);

	logic [FACT_W-1:0]  hn_q, vn_q;
	logic [SCALE_W-1:0] scale_q;
	logic               cfg_wr;
	back_stat_t         stat;
	logic               q_valid, q_pop;
	item_t              q_item;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [CODE_W-1:0]  ram_wdata, ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hn_q    <= HN_RESET;
			vn_q    <= VN_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_HN:    hn_q    <= pwdata[FACT_W-1:0];
				REG_VN:    vn_q    <= pwdata[FACT_W-1:0];
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HN:    prdata = 32'(hn_q);
			REG_VN:    prdata = 32'(vn_q);
			REG_SCALE: prdata = 32'(scale_q);
			default:   prdata = '0;
		endcase
	end

	ppdif_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.query_column (query_column),
		.query_row    (query_row),
		.stat         (stat),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	ppdif_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop),
		.stat              (stat),
		.horizontal_factor (hn_q),
		.vertical_factor   (vn_q),
		.depth_scale       (scale_q),
		.ram_we            (ram_we),
		.ram_waddr         (ram_waddr),
		.ram_wdata         (ram_wdata),
		.ram_raddr         (ram_raddr),
		.ram_rdata         (ram_rdata),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.depth_code        (depth_code)
	);

	ppdif_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import ppdif_pkg::*;

	localparam int  STALL_LIMIT = 400000;
	localparam int  HOLD_CYCLES = 4000;
	localparam longint M = 65536;

	typedef struct {
		cmd_t              cmd;
		logic signed [31:0] x, y, z;
		logic [8:0]         col;
		logic [7:0]         row;
	} order_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [3:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 0;
	logic        item_ready;
	logic [1:0]  command = 0;
	logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
	logic [8:0]  query_column = 0;
	logic [7:0]  query_row = 0;
	logic        result_valid;
	logic        result_ready = 0;
	logic [7:0]  depth_code;

	point_projection_depth_image_fill dut (.*);

	always #5 clk = ~clk;

	order_t      pending[$];
	logic [7:0]  code_due[$];
	logic [7:0]  pixel_mem[COLUMNS*ROWS] = '{default: 8'd0};
	logic [15:0] hn = HN_RESET, vn = VN_RESET;
	logic [7:0]  scale = SCALE_RESET;
	int          errors = 0, sent = 0, idle_cycles = 0, hold_left = 0;
	bit          held = 0;
	int          hit_col[$], hit_row[$];

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] rt, b;
		rt = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= rt + b) begin
				v -= rt + b;
				rt = (rt >> 1) + b;
			end else begin
				rt >>= 1;
			end
			b >>= 2;
		end
		return rt;
	endfunction

	function automatic int cell_index(longint p, longint den, int size);
		longint idx;
		idx = ((den - p) * size) / (2 * den);
		return (idx > size - 1) ? size - 1 : int'(idx);
	endfunction

	// pinhole projection and distance code of one point
	function automatic void project(input logic signed [31:0] px, py, pz, output bit kept,
			output int c, output int r, output logic [7:0] code);
		longint x, y, z, ay, den, ph, pv;
		logic [63:0] s, rt;
		x = px; y = py; z = pz;
		kept = 0; c = 0; r = 0; code = 0;
		ay = (y < 0) ? -y : y;
		if (x <= 0 || x < ay) return;
		den = x * 4096;
		ph = longint'(hn) * y;
		pv = longint'(vn) * z;
		if (ph < -den || ph > den || pv < -den || pv > den) return;
		kept = 1;
		c = cell_index(ph, den, COLUMNS);
		r = cell_index(pv, den, ROWS);
		s = 64'(x * x) + 64'(y * y) + 64'(z * z);
		if (s > (64'd1 << 48)) begin
			code = (scale == 0) ? 8'd0 : 8'd255;
		end else begin
			rt = root64(64'(scale) * 64'(scale) * s) >> 16;
			code = (rt > 255) ? 8'd255 : rt[7:0];
		end
	endfunction

	function automatic logic [7:0] fill_lookup(int qc, int qr);
		int best, d, c, r;
		logic [7:0] found, v;
		best = SEARCH_RADIUS * SEARCH_RADIUS;
		found = 0;
		if (qc >= COLUMNS || qr >= ROWS) return 0;
		if (pixel_mem[qc + qr*COLUMNS] != 0) return pixel_mem[qc + qr*COLUMNS];
		for (int dc = -SEARCH_RADIUS; dc <= SEARCH_RADIUS; dc++)
			for (int dr = -SEARCH_RADIUS; dr <= SEARCH_RADIUS; dr++) begin
				c = qc + dc;
				r = qr + dr;
				d = dc*dc + dr*dr;
				if (c < 0 || c >= COLUMNS || r < 0 || r >= ROWS) continue;
				v = pixel_mem[c + r*COLUMNS];
				if (v != 0 && d < best) begin
					best = d;
					found = v;
				end
			end
		return found;
	endfunction

	task automatic apply_order(order_t o);
		bit kept;
		int c, r;
		logic [7:0] code;
		case (o.cmd)
			CMD_CLEAR: foreach (pixel_mem[i]) pixel_mem[i] = 0;
			CMD_POINT: begin
				project(o.x, o.y, o.z, kept, c, r, code);
				if (kept) pixel_mem[c + r*COLUMNS] = code;
			end
			CMD_QUERY: code_due.push_back(fill_lookup(o.col, o.row));
			default: ;
		endcase
	endtask

	function automatic order_t mk(cmd_t cmd, longint x = 0, longint y = 0, longint z = 0,
			int c = 0, int r = 0);
		order_t o;
		o.cmd = cmd; o.x = 32'(x); o.y = 32'(y); o.z = 32'(z);
		o.col = 9'(c); o.row = 8'(r);
		return o;
	endfunction

	function automatic order_t rand_point();
		longint x, zl;
		bit kept;
		int c, r;
		logic [7:0] code;
		order_t o;
		x = $urandom_range(($urandom_range(3) == 0) ? 300 : 40 * M, 1);
		zl = x * 4096 / vn + 2;
		o = mk(CMD_POINT, x, longint'($urandom_range(2*x + 2)) - x - 1,
			longint'($urandom_range(2*zl)) - zl);
		project(o.x, o.y, o.z, kept, c, r, code);
		if (kept) begin
			hit_col.push_back(c);
			hit_row.push_back(r);
		end
		return o;
	endfunction

	function automatic order_t rand_query();
		int k, c, r;
		if (hit_col.size() == 0 || $urandom_range(99) < 30)
			return mk(CMD_QUERY, 0, 0, 0, $urandom_range(511), $urandom_range(255));
		k = $urandom_range(hit_col.size() - 1);
		c = hit_col[k] + int'($urandom_range(16)) - 8;
		r = hit_row[k] + int'($urandom_range(16)) - 8;
		return mk(CMD_QUERY, 0, 0, 0, (c < 0) ? 0 : c, (r < 0) ? 0 : r);
	endfunction

	task automatic fill_random(int n);
		int p;
		order_t o;
		repeat (n) begin
			p = $urandom_range(99);
			if (p < 45) begin
				o = rand_point();
			end else if (p < 92) begin
				o = rand_query();
			end else begin
				// unconstrained noise, unused command included
				o = mk(cmd_t'($urandom_range(3, 1)), $urandom, $urandom, $urandom,
					$urandom_range(511), $urandom_range(255));
			end
			pending.push_back(o);
		end
		pending.push_back(rand_query());
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx * 4); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_HN:  hn = v[15:0];
			REG_VN:  vn = v[15:0];
			default: scale = v[7:0];
		endcase
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !item_valid && code_due.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] h, logic [15:0] v, logic [7:0] s);
		reg_write(REG_HN, h);
		reg_write(REG_VN, v);
		reg_write(REG_SCALE, s);
		hit_col.delete();
		hit_row.delete();
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				apply_order('{cmd_t'(command), point_x, point_y, point_z,
					query_column, query_row});
				sent++;
			end
			if (!item_valid || item_ready) begin
				if (pending.size() != 0 &&
						((sent >= 200 && sent < 350) || $urandom_range(99) >= 21)) begin
					order_t o;
					o = pending.pop_front();
					command <= o.cmd; point_x <= o.x; point_y <= o.y; point_z <= o.z;
					query_column <= o.col; query_row <= o.row;
					item_valid <= 1;
				end else begin
					item_valid <= 0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (code_due.size() == 0) begin
					$error("depth_code transfer with nothing expected, got %0d", depth_code);
					errors++;
				end else begin
					logic [7:0] want;
					want = code_due.pop_front();
					if (depth_code !== want) begin
						$error("depth_code expected %0d got %0d", want, depth_code);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 0;
			end else if (!held && sent >= 500) begin
				held <= 1;
				hold_left <= HOLD_CYCLES;
				result_ready <= 0;
			end else begin
				result_ready <= (sent >= 200 && sent < 350) || ($urandom_range(99) >= 21);
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// edge of view needs unit factors
		configure(16'd4096, 16'd4096, 8'd255);
		pending.push_back(mk(CMD_CLEAR));
		pending.push_back(mk(CMD_POINT, 0, 0, 0));
		pending.push_back(mk(CMD_POINT, -M, 0, 0));
		pending.push_back(mk(CMD_POINT, M, 2*M, 0));
		pending.push_back(mk(CMD_POINT, M, -M, 0));
		pending.push_back(mk(CMD_POINT, M, M, -M));
		pending.push_back(mk(CMD_POINT, M, 0, 2*M));
		pending.push_back(mk(CMD_POINT, 1, 0, 0));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 192, 108));
		pending.push_back(mk(CMD_POINT, 32'h7fffffff, 0, 0));
		pending.push_back(mk(CMD_POINT, 32'h7fffffff, -32'sh80000000, 0));
		pending.push_back(mk(CMD_POINT, M/4, -M/8, M/8));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 383, 108));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 215));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 192, 108));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 380, 108));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 376, 108));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 511, 255));
		pending.push_back(mk(CMD_NONE, -1, -1, -1, 511, 255));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_QUERY, 0, 0, 0, 100, 100));
		drain();

		configure(HN_RESET, VN_RESET, SCALE_RESET);
		fill_random(240);
		drain();
		configure(16'hffff, 16'hffff, 8'd255);
		pending.push_back(mk(CMD_CLEAR));
		fill_random(230);
		drain();
		configure(16'd1, 16'd1, 8'd1);
		fill_random(230);
		drain();
		configure(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
			8'($urandom_range(255, 1)));
		pending.push_back(mk(CMD_CLEAR));
		fill_random(230);
		drain();

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
